// File: design/sai_pkg.sv
// ----------------------------------------------------------------------------
// sai_pkg
// Shared constants, codes and types of the sorted store with insert, remove
// and search.
// ----------------------------------------------------------------------------
package sai_pkg;

	localparam int DEPTH_DEF       = 128;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FUNC_W          = 2;
	localparam int STATUS_W        = 2;
	localparam int IN_VALUE_W      = 32;
	localparam int RSP_POS_W       = 7;
	localparam int RSP_CNT_W       = 8;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic cmp;      // register compare flags
		logic le_mode;  // flag means entry <= key instead of entry < key
		logic ins;      // open a slot at pos and write key there
		logic rem;      // close the slot at pos
	} cell_ctl_t;

endpackage

// File: design/sai_if.sv
// ----------------------------------------------------------------------------
// sai_if
// Valid/ready channels for requests and responses of the sorted store.
// ----------------------------------------------------------------------------
interface sai_req_if import sai_pkg::*;
	#(parameter int VW = IN_VALUE_W);
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic signed [VW-1:0] value;

	modport source(output valid, func, value, input ready);
	modport sink(input valid, func, value, output ready);
endinterface

interface sai_rsp_if import sai_pkg::*;
	#(parameter int POS_W = RSP_POS_W, parameter int CNT_W = RSP_CNT_W);
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [CNT_W-1:0]    count_after;

	modport source(output valid, status, position, count_after, input ready);
	modport sink(input valid, status, position, count_after, output ready);
endinterface

// File: design/sorted_array_insert_remove_search.sv
// ----------------------------------------------------------------------------
// sorted_array_insert_remove_search
// Sorted store of signed values kept in a row of cells, with insert after
// equal entries, remove of the first equal entry and query of its position.
// ----------------------------------------------------------------------------
//  channel  dir  fields                              transaction
//  req      in   func, value                         valid & ready
//  rsp      out  status, position, count_after       valid & ready
//
//  the time each request takes is set by the position search, which
//  resolves one bit of the position per cycle
//  all cells compare in the same cycle and shift together on insert or remove
//  arst_n clears the fill count and the sequencer; entries need no clearing
//  a response still waiting holds the sequencer before the store is updated,
//  and no new request is taken until the sequencer is back in idle
// ----------------------------------------------------------------------------
module sorted_array_insert_remove_search import sai_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sai_req_if.sink   req,
	sai_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_SRCH, S_APPLY} state_t;

	state_t              state_q;
	logic [FUNC_W-1:0]   func_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CW-1:0]       cnt_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [AW-1:0]       pos_q;
	logic [CW-1:0]       cnt_out_q;

	logic [VALUE_WIDTH-1:0] in_key;
	logic [VALUE_WIDTH-1:0] ent [DEPTH];
	logic [DEPTH-1:0]    flags;
	logic [DEPTH-1:0]    eqs;
	logic                srch_done;
	logic [CW-1:0]       srch_pos;
	logic                adv;
	logic                full;
	logic                found;
	logic [STATUS_W-1:0] status_d;
	logic [AW-1:0]       pos_d;
	logic [CW-1:0]       cnt_d;
	cell_ctl_t           ctl;

	// offset binary, so unsigned compares give signed order
	assign in_key = VALUE_WIDTH'(req.value) ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH - 1));

	assign req.ready = (state_q == S_IDLE);
	assign adv       = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);
	assign full      = (cnt_q == CW'(DEPTH));
	assign found     = (srch_pos < cnt_q) && eqs[srch_pos[AW-1:0]];

	always_comb begin
		status_d = ST_OK;
		pos_d    = '0;
		cnt_d    = cnt_q;
		unique case (func_q)
			FN_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					pos_d = srch_pos[AW-1:0];
					cnt_d = cnt_q + CW'(1);
				end
			end
			FN_REMOVE: begin
				if (found) begin
					pos_d = srch_pos[AW-1:0];
					cnt_d = cnt_q - CW'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			FN_QUERY: begin
				if (found) begin
					pos_d = srch_pos[AW-1:0];
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		ctl.cmp     = (state_q == S_CMP);
		ctl.le_mode = (func_q == FN_INSERT);
		ctl.ins     = adv && (func_q == FN_INSERT) && !full;
		ctl.rem     = adv && (func_q == FN_REMOVE) && found;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.func;
			key_q  <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_OK;
			pos_q       <= '0;
			cnt_out_q   <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && !adv) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (srch_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (adv) begin
						state_q     <= S_IDLE;
						cnt_q       <= cnt_d;
						rsp_valid_q <= 1'b1;
						status_q    <= status_d;
						pos_q       <= pos_d;
						cnt_out_q   <= cnt_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// row of cells, each handing its entry to both neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam int LI = (g == 0) ? 0 : g - 1;
		localparam int RI = (g == DEPTH - 1) ? g : g + 1;

		sai_cell #(
			.IDX(g),
			.VW (VALUE_WIDTH),
			.CW (CW)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.cnt  (cnt_q),
			.pos  (srch_pos),
			.key  (key_q),
			.left (ent[LI]),
			.right(ent[RI]),
			.entry(ent[g]),
			.flag (flags[g]),
			.eq   (eqs[g])
		);
	end

	sai_srch #(
		.DEPTH(DEPTH),
		.CW   (CW)
	) u_srch (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.cmp),
		.flags (flags),
		.done  (srch_done),
		.pos   (srch_pos)
	);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.position    = RSP_POS_W'(pos_q);
	assign rsp.count_after = RSP_CNT_W'(cnt_out_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_srch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> (srch_pos <= cnt_q))
		else $error("search position beyond fill count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q == ST_FULL)) |-> (cnt_out_q == CW'(DEPTH)))
		else $error("full status with room left");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q == ST_NOT_FOUND)) |-> (pos_q == '0))
		else $error("nonzero position on a miss");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_APPLY) |=> $stable(cnt_q))
		else $error("fill count moved outside the update cycle");

endmodule

// File: design/sai_cell.sv
// ----------------------------------------------------------------------------
// sai_cell
// One slot of the sorted store: holds an entry, compares it with the
// broadcast key, takes its left neighbor or the key on insert, its right one on remove.
// ----------------------------------------------------------------------------
module sai_cell import sai_pkg::*; #(
	parameter int IDX = 0,
	parameter int VW  = VALUE_WIDTH_DEF,
	parameter int CW  = 8
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] cnt,
	input  logic [CW-1:0] pos,
	input  logic [VW-1:0] key,
	input  logic [VW-1:0] left,
	input  logic [VW-1:0] right,
	output logic [VW-1:0] entry,
	output logic          flag,
	output logic          eq
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [VW-1:0] entry_q;
	logic          flag_q;
	logic          eq_q;
	logic          occ;

	// slots at or above the fill count hold nothing and never match
	assign occ = MY_IDX < cnt;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			flag_q <= occ && (ctl.le_mode ? (entry_q <= key) : (entry_q < key));
			eq_q   <= occ && (entry_q == key);
		end
		if (ctl.ins) begin
			if (MY_IDX > pos) begin
				entry_q <= left;
			end else if (MY_IDX == pos) begin
				entry_q <= key;
			end
		end else if (ctl.rem && (MY_IDX >= pos)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign flag  = flag_q;
	assign eq    = eq_q;

endmodule

// File: design/sai_srch.sv
// ----------------------------------------------------------------------------
// sai_srch
// Finds the length of the run of ones from bit 0 up in the cells' flag vector,
// one result bit per cycle from the top bit down.
// ----------------------------------------------------------------------------
module sai_srch import sai_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CW    = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEPTH-1:0] flags,
	output logic             done,
	output logic [CW-1:0]    pos
);

	localparam int AW = $clog2(DEPTH);
	localparam int BW = (CW > 1) ? $clog2(CW) : 1;

	logic [CW-1:0] p_q;
	logic [BW-1:0] b_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cand;
	logic [CW-1:0] idx;
	logic          take;

	// flags form a prefix of ones, so a candidate length is good when its last bit is set
	assign cand = p_q | (CW'(1) << b_q);
	assign idx  = cand - CW'(1);
	assign take = (cand <= CW'(DEPTH)) && flags[idx[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			b_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				p_q    <= '0;
				b_q    <= BW'(CW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (take) begin
					p_q <= cand;
				end
				if (b_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					b_q <= b_q - BW'(1);
				end
			end
		end
	end

	assign done = done_q;
	assign pos  = p_q;

endmodule

// File: tb/tb_sorted_array_insert_remove_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_array_insert_remove_search
// Drives insert, remove, query and unused operations into the sorted store,
// predicts each response from a local copy of the store and checks every
// response field, under random idle cycles and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_array_insert_remove_search;
	import sai_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 40;
	localparam int MAX_REPORTS = 40;
	localparam int HOLD_CYCLES = 180;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam logic signed [IN_VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic signed [IN_VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [6:0]          position;
		logic [7:0]          count_after;
	} store_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sai_req_if req_ch();
	sai_rsp_if rsp_ch();

	sorted_array_insert_remove_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// local copy of the sorted store
	logic signed [IN_VALUE_W-1:0] held_vals [DEPTH];
	int held_count = 0;

	store_result_t expected_results [$];

	int  cycle_count    = 0;
	int  mismatch_count = 0;
	int  checked_count  = 0;
	int  op_count [4]   = '{default: 0};
	int  full_refusals  = 0;
	int  misses         = 0;
	bit  no_idle        = 1'b0;
	int  hold_request   = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses pending", cycle_count,
				expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int first_equal_index(input logic signed [IN_VALUE_W-1:0] v);
		int i;
		for (i = 0; i < held_count; i++)
			if (held_vals[i] == v)
				return i;
		return held_count;
	endfunction

	function automatic store_result_t predict_op(input logic [FUNC_W-1:0] f,
		input logic signed [IN_VALUE_W-1:0] v);
		store_result_t r;
		int at;
		int i;
		r.status   = ST_OK;
		r.position = '0;
		case (f)
			FN_INSERT: begin
				if (held_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// new value goes after any equal entries
					at = 0;
					while (at < held_count && !(v < held_vals[at]))
						at++;
					for (i = held_count; i > at; i--)
						held_vals[i] = held_vals[i-1];
					held_vals[at] = v;
					held_count++;
					r.position = 7'(at);
				end
			end
			FN_REMOVE: begin
				at = first_equal_index(v);
				if (at >= held_count) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (i = at; i + 1 < held_count; i++)
						held_vals[i] = held_vals[i+1];
					held_count--;
					r.position = 7'(at);
				end
			end
			FN_QUERY: begin
				at = first_equal_index(v);
				if (at >= held_count)
					r.status = ST_NOT_FOUND;
				else
					r.position = 7'(at);
			end
			default: begin
			end
		endcase
		r.count_after = 8'(held_count);
		return r;
	endfunction

	// dense small values give duplicates and hits, the rest spans the full range
	function automatic logic signed [IN_VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $signed($urandom_range(0, 15)) - 8;
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic signed [IN_VALUE_W-1:0] pick_present();
		if (held_count == 0)
			return pick_value();
		return held_vals[$urandom_range(0, held_count - 1)];
	endfunction

	// leaves valid high so that a back-to-back transaction needs no toggle
	task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [IN_VALUE_W-1:0] v);
		store_result_t want;
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) >= 60)
			gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.value <= v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		want = predict_op(f, v);
		expected_results.push_back(want);
		op_count[f]++;
		if (want.status == ST_FULL)
			full_refusals++;
		if (want.status == ST_NOT_FOUND)
			misses++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_edge_values();
		send_op(FN_QUERY, 0);
		send_op(FN_REMOVE, 0);
		send_op(FN_UNUSED, VAL_MAX);
		send_op(FN_INSERT, VAL_MIN);
		send_op(FN_INSERT, VAL_MAX);
		send_op(FN_INSERT, 0);
		send_op(FN_INSERT, 0);
		send_op(FN_INSERT, -1);
		send_op(FN_INSERT, 1);
		send_op(FN_INSERT, 32'h5555_5555);
		send_op(FN_INSERT, 32'haaaa_aaaa);
		send_op(FN_QUERY, 0);
		send_op(FN_QUERY, VAL_MAX);
		send_op(FN_QUERY, VAL_MIN);
		send_op(FN_QUERY, 5);
		send_op(FN_INSERT, 0);
		send_op(FN_REMOVE, 0);
		send_op(FN_REMOVE, VAL_MIN);
		send_op(FN_REMOVE, VAL_MAX);
		send_op(FN_REMOVE, 12345);
		send_op(FN_UNUSED, VAL_MIN);
		send_op(FN_QUERY, -1);
		send_op(FN_QUERY, 1);
		wait_drained();
	endtask

	// fill to capacity, poke the full store, then empty it again
	task automatic test_full_store();
		while (held_count < DEPTH)
			send_op(FN_INSERT, pick_value());
		send_op(FN_INSERT, VAL_MAX);
		send_op(FN_INSERT, VAL_MIN);
		send_op(FN_INSERT, pick_value());
		send_op(FN_QUERY, pick_present());
		send_op(FN_QUERY, pick_value());
		send_op(FN_UNUSED, pick_value());
		send_op(FN_REMOVE, pick_present());
		send_op(FN_INSERT, VAL_MIN);
		while (held_count > 0)
			send_op(FN_REMOVE, ($urandom_range(0, 9) < 8) ? pick_present() : pick_value());
		send_op(FN_REMOVE, VAL_MIN);
		send_op(FN_QUERY, VAL_MAX);
		wait_drained();
	endtask

	task automatic test_random_ops(input int n);
		logic [FUNC_W-1:0] f;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			f = (r < 40) ? FN_INSERT : (r < 70) ? FN_REMOVE : (r < 95) ? FN_QUERY : FN_UNUSED;
			if (f != FN_INSERT && $urandom_range(0, 99) < 65)
				send_op(f, pick_present());
			else
				send_op(f, pick_value());
		end
		wait_drained();
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		int i;
		hold_request = HOLD_CYCLES;
		no_idle = 1'b1;
		for (i = 0; i < 40; i++)
			send_op((i % 3 == 0) ? FN_INSERT : (i % 3 == 1) ? FN_QUERY : FN_REMOVE,
				(i % 3 == 0) ? pick_value() : pick_present());
		no_idle = 1'b0;
		wait_drained();
	endtask

	task automatic test_no_idling();
		no_idle = 1'b1;
		test_random_ops(150);
		no_idle = 1'b0;
	endtask

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0 && !no_idle) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				stall_left = 0;
				rsp_ch.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 99) < 15)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		store_result_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("response %0d status %0d, expected %0d",
						checked_count, rsp_ch.status, want.status));
				if (rsp_ch.position !== want.position)
					report_mismatch($sformatf("response %0d position %0d, expected %0d",
						checked_count, rsp_ch.position, want.position));
				if (rsp_ch.count_after !== want.count_after)
					report_mismatch($sformatf("response %0d count_after %0d, expected %0d",
						checked_count, rsp_ch.count_after, want.count_after));
			end
			checked_count++;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func  = FN_INSERT;
		req_ch.value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_values();
		test_full_store();
		test_random_ops(400);
		test_backpressure();
		test_no_idling();
		test_full_store();
		test_random_ops(350);

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("covered: %0d responses checked; %0d insert, %0d remove, %0d query, %0d unused",
			checked_count, op_count[FN_INSERT], op_count[FN_REMOVE], op_count[FN_QUERY],
			op_count[FN_UNUSED]);
		$display("covered: %0d refused on a full store, %0d lookups missed, %0d mismatches",
			full_refusals, misses, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
